>>> hw/rtl/rliu_pkg.sv
// Shared types and constants for the raster line interrupt unit.
// Holds the channel payload structs, the sequencer states and the register map.
// No dependencies.
package rliu_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [8:0] raster_line;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    logic [5:0] rd_addr;
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP,
    ST_FIN
  } state_t;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [5:0] REG_CTRL1    = 6'h11;
  localparam logic [5:0] REG_RASTER   = 6'h12;
  localparam logic [5:0] REG_IRQ_FLAG = 6'h19;
  localparam logic [5:0] REG_IRQ_EN   = 6'h1A;

  localparam logic [8:0] CPL_PAL  = 9'd63;
  localparam logic [8:0] CPL_NTSC = 9'd65;
  localparam logic [8:0] LPF_PAL  = 9'd312;
  localparam logic [8:0] LPF_NTSC = 9'd262;

  localparam logic [7:0] FLAG_READ_BASE = 8'h70;

endpackage

>>> hw/rtl/rliu_regmem.sv
// 64-byte register file: synchronous memory with registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on rliu_pkg.
module rliu_regmem
  import rliu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]  mem [64];
  logic [63:0] valid_r;
  logic [7:0]  q_r;
  logic        q_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        q_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rdata = q_valid_r ? q_r : 8'h00;

endmodule

>>> hw/rtl/raster_line_interrupt_unit_core.sv
// Top level of the raster line interrupt unit: sequencer, raster state, output register.
// Depends on rliu_pkg and rliu_regmem.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_item_t
//   out_    | output    | out_valid/out_stall | out_item_t
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_data (ntsc_mode)
//
// A read or write passes from acceptance through EXEC to FIN; a tick passes through EXEC,
// the line loop and FIN, advancing whole lines (at most 5), one line a cycle in the line
// loop. The result goes into the output register in FIN once the output is free.
// The register file read is registered: address at acceptance, data used in EXEC.
// Reset is synchronous, active low; no clearing pass. A result waiting in the output
// register does not block acceptance; a stalled output holds the next result in FIN.
module raster_line_interrupt_unit_core
  import rliu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  state_t    state_r, state_nxt;
  in_item_t  item_r;
  logic [8:0] acc_r, acc_nxt;
  logic [8:0] raster_r, raster_nxt;
  logic [8:0] cmp_r, cmp_nxt;
  logic [3:0] flags_r, flags_nxt;
  logic [3:0] en_r, en_nxt;
  logic       irq_r, irq_nxt;
  logic       ntsc_r;
  logic [7:0] rd_r, rd_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  logic [8:0] cpl, lpf, acc_sum, line_inc, line_next;
  logic       out_free, line_due;
  logic [3:0] flags_write;

  rliu_regmem u_regmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign cpl         = ntsc_r ? CPL_NTSC : CPL_PAL;
  assign lpf         = ntsc_r ? LPF_NTSC : LPF_PAL;
  assign acc_sum     = acc_r + {1'b0, item_r.cycles};
  assign line_due    = (acc_r >= cpl);
  assign line_inc    = raster_r + 9'd1;
  assign line_next   = (line_inc >= lpf) ? 9'd0 : line_inc;
  assign flags_write = flags_r & ~item_r.write_data[3:0];
  assign out_free    = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = (item_r.action == ACT_TICK) ? ST_LOOP : ST_FIN;
      end
      ST_LOOP: begin
        if (!line_due) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    raster_nxt    = raster_r;
    cmp_nxt       = cmp_r;
    flags_nxt     = flags_r;
    en_nxt        = en_r;
    irq_nxt       = irq_r;
    rd_nxt        = rd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_req       = '0;
    case (state_r)
      ST_IDLE: begin
        mem_req.rd_en   = in_valid;
        mem_req.rd_addr = in_data.reg_index;
      end
      ST_EXEC: begin
        rd_nxt = 8'h00;
        case (item_r.action)
          ACT_READ: begin
            case (item_r.reg_index)
              REG_RASTER:   rd_nxt = raster_r[7:0];
              REG_CTRL1:    rd_nxt = {raster_r[8], mem_rdata[6:0]};
              REG_IRQ_FLAG: rd_nxt = FLAG_READ_BASE | {irq_r, 3'b000, flags_r};
              default:      rd_nxt = mem_rdata;
            endcase
          end
          ACT_WRITE: begin
            if (item_r.reg_index == REG_IRQ_FLAG) begin
              flags_nxt = flags_write;
              irq_nxt   = |(flags_write & en_r);
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = item_r.reg_index;
              mem_req.wr_data = item_r.write_data;
            end
            if (item_r.reg_index == REG_IRQ_EN) begin
              en_nxt  = item_r.write_data[3:0];
              irq_nxt = |(flags_r & item_r.write_data[3:0]);
            end
            if (item_r.reg_index == REG_CTRL1) cmp_nxt[8] = item_r.write_data[7];
            if (item_r.reg_index == REG_RASTER) cmp_nxt[7:0] = item_r.write_data;
          end
          ACT_TICK: begin
            acc_nxt = acc_sum;
          end
          default: begin
            rd_nxt = 8'h00;
          end
        endcase
      end
      ST_LOOP: begin
        if (line_due) begin
          acc_nxt    = acc_r - cpl;
          raster_nxt = line_next;
          if (line_next == cmp_r) begin
            flags_nxt = flags_r | 4'b0001;
            irq_nxt   = |((flags_r | 4'b0001) & en_r);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.read_data   = rd_r;
          out_data_nxt.irq         = irq_r;
          out_data_nxt.raster_line = raster_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      raster_r    <= '0;
      cmp_r       <= '0;
      flags_r     <= '0;
      en_r        <= '0;
      irq_r       <= 1'b0;
      ntsc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      raster_r    <= raster_nxt;
      cmp_r       <= cmp_nxt;
      flags_r     <= flags_nxt;
      en_r        <= en_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) ntsc_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) item_r <= in_data;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not enter execute");

  a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r == (|(flags_r & en_r)))
    else $error("interrupt line disagrees with pending and enabled flags");

  a_loop_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP) |-> (item_r.action == ACT_TICK))
    else $error("line loop entered for a non-tick transaction");

  a_fin_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && item_r.action == ACT_TICK) |-> (acc_r < cpl))
    else $error("tick finished with a whole line left in the accumulator");
`endif

endmodule
